@@ rtl/cbm_pkg.sv @@
// Shared types and codes for the corridor breach monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam int MarginW  = 32;
    localparam int TimeW    = 32;
    localparam int ThreshW  = 31;
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 32;

    // Register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] REG_CORRIDOR_LOADED = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_WARN_MARGIN     = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_CLEAR_MARGIN    = 2'd2;
    localparam logic [CfgAddrW-1:0] REG_BREACH_HOLD     = 2'd3;

    // Reported corridor state
    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_INSIDE  = 2'd1,
        ST_WARNING = 2'd2,
        ST_BREACH  = 2'd3
    } corridor_state_t;

    typedef struct packed {
        logic               corridor_loaded;
        logic [ThreshW-1:0] warn_margin_mm;
        logic [ThreshW-1:0] clear_margin_mm;
        logic [TimeW-1:0]   breach_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [MarginW-1:0] margin_mm;
        logic                      margin_valid;
        logic [TimeW-1:0]          now_ms;
    } sample_t;

    typedef struct packed {
        corridor_state_t           corridor_state;
        logic signed [MarginW-1:0] margin_echo_mm;
        logic                      breach_entered;
        logic                      breach_cleared;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/cbm_cfg_regs.sv @@
// Configuration register file of the corridor breach monitor.
// Depends on cbm_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module cbm_cfg_regs (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [cbm_pkg::CfgAddrW-1:0]       cfg_addr,
    input  wire  [cbm_pkg::CfgDataW-1:0]       cfg_wdata,
    output cbm_pkg::cfg_t                      cfg
);

    cbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.corridor_loaded <= 1'b0;
            cfg_reg.warn_margin_mm  <= cbm_pkg::ThreshW'(20000);
            cfg_reg.clear_margin_mm <= cbm_pkg::ThreshW'(30000);
            cfg_reg.breach_hold_ms  <= cbm_pkg::TimeW'(1000);
        end else if (cfg_we) begin
            case (cfg_addr)
                cbm_pkg::REG_CORRIDOR_LOADED: begin
                    cfg_reg.corridor_loaded <= cfg_wdata[0];
                end
                cbm_pkg::REG_WARN_MARGIN: begin
                    cfg_reg.warn_margin_mm <= cfg_wdata[cbm_pkg::ThreshW-1:0];
                end
                cbm_pkg::REG_CLEAR_MARGIN: begin
                    cfg_reg.clear_margin_mm <= cfg_wdata[cbm_pkg::ThreshW-1:0];
                end
                cbm_pkg::REG_BREACH_HOLD: begin
                    cfg_reg.breach_hold_ms <= cfg_wdata[cbm_pkg::TimeW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/cbm_classify.sv @@
// Per-sample classification and the tracking state it carries between samples.
// Depends on cbm_pkg for cfg_t, sample_t, result_t and the state codes.
`timescale 1ns / 1ps
`default_nettype none

module cbm_classify (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step,
    input  cbm_pkg::cfg_t        cfg,
    input  cbm_pkg::sample_t     sample,
    output cbm_pkg::result_t     res
);

    cbm_pkg::corridor_state_t        current_state_reg, current_state_next;
    logic                            breach_pending_reg, breach_pending_next;
    logic [cbm_pkg::TimeW-1:0]       first_outside_time_reg, first_outside_time_next;
    logic                            breach_seen_reg, breach_seen_next;

    logic                            unknown;
    logic                            outside;
    logic [cbm_pkg::TimeW-1:0]       held;
    logic signed [cbm_pkg::MarginW-1:0] warn_s;
    logic signed [cbm_pkg::MarginW-1:0] clear_s;
    cbm_pkg::corridor_state_t        desired;
    logic                            jb;
    logic                            jc;

    assign unknown = !cfg.corridor_loaded || !sample.margin_valid;
    assign outside = sample.margin_mm[cbm_pkg::MarginW-1];
    assign warn_s  = $signed({1'b0, cfg.warn_margin_mm});
    assign clear_s = $signed({1'b0, cfg.clear_margin_mm});

    always_comb begin
        breach_pending_next     = breach_pending_reg;
        first_outside_time_next = first_outside_time_reg;
        desired                 = cbm_pkg::ST_UNKNOWN;
        held                    = '0;
        if (!unknown) begin
            if (outside) begin
                breach_pending_next = 1'b1;
                if (!breach_pending_reg) begin
                    first_outside_time_next = sample.now_ms;
                end
                // wraps mod 2^32
                held = sample.now_ms - first_outside_time_next;
                if (held >= cfg.breach_hold_ms) begin
                    desired = cbm_pkg::ST_BREACH;
                end else if (current_state_reg == cbm_pkg::ST_UNKNOWN) begin
                    desired = cbm_pkg::ST_WARNING;
                end else begin
                    desired = current_state_reg;
                end
            end else begin
                breach_pending_next = 1'b0;
                if (current_state_reg == cbm_pkg::ST_BREACH) begin
                    desired = (sample.margin_mm >= clear_s) ? cbm_pkg::ST_INSIDE
                                                            : cbm_pkg::ST_WARNING;
                end else if (sample.margin_mm < warn_s) begin
                    desired = cbm_pkg::ST_WARNING;
                end else begin
                    desired = cbm_pkg::ST_INSIDE;
                end
            end
        end
    end

    assign jb = !unknown && (current_state_reg != cbm_pkg::ST_BREACH)
                && (desired == cbm_pkg::ST_BREACH);
    assign jc = !unknown && (breach_seen_reg || desired == cbm_pkg::ST_BREACH)
                && (desired == cbm_pkg::ST_INSIDE);

    always_comb begin
        breach_seen_next = breach_seen_reg;
        if (!unknown) begin
            if (desired == cbm_pkg::ST_BREACH) begin
                breach_seen_next = 1'b1;
            end else if (jc) begin
                breach_seen_next = 1'b0;
            end
        end
    end

    assign current_state_next = desired;

    always_comb begin
        res.corridor_state = desired;
        res.margin_echo_mm = unknown ? '0 : sample.margin_mm;
        res.breach_entered = jb;
        res.breach_cleared = jc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_state_reg      <= cbm_pkg::ST_UNKNOWN;
            breach_pending_reg     <= 1'b0;
            first_outside_time_reg <= '0;
            breach_seen_reg        <= 1'b0;
        end else if (step) begin
            current_state_reg      <= current_state_next;
            breach_pending_reg     <= breach_pending_next;
            first_outside_time_reg <= first_outside_time_next;
            breach_seen_reg        <= breach_seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_jb_is_breach: assert property (@(posedge aclk) disable iff (!aresetn)
        step && jb |-> desired == cbm_pkg::ST_BREACH)
        else $error("breach entry flagged without breach state");

    a_jc_needs_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        step && jc |-> breach_seen_reg && desired == cbm_pkg::ST_INSIDE)
        else $error("breach clear flagged without a prior breach");

    a_unknown_state: assert property (@(posedge aclk) disable iff (!aresetn)
        step && unknown |=> current_state_reg == cbm_pkg::ST_UNKNOWN
                            && $stable(breach_pending_reg) && $stable(breach_seen_reg))
        else $error("unknown sample disturbed tracking state");

    a_breach_marks_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !unknown && desired == cbm_pkg::ST_BREACH |=> breach_seen_reg)
        else $error("breach not recorded");

    a_outside_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !unknown && outside |=> breach_pending_reg)
        else $error("outside run not timed");
`endif

endmodule

`default_nettype wire

@@ rtl/corridor_breach_monitor.sv @@
// Top level of the corridor breach monitor: stream ports, input and result registers.
// Depends on cbm_pkg, cbm_cfg_regs and cbm_classify.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave channel s_*: one position sample per beat. s_tdata carries margin_mm
//   (signed, bits 31:0) and now_ms (bits 63:32); s_tuser carries margin_valid.
//   Master channel m_*: one result per sample. m_tdata is margin_echo_mm;
//   m_tuser holds corridor_state, breach_entered and breach_cleared.
//   Config port: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
//   write only while no sample is in flight.
// Path: a sample accepted into the input register is classified combinationally
//   and its result is written to the result register that drives m_*.
// Throughput: one sample per cycle while m_tready is high. The rate is set by the single compare-
//   and-select step that reads and updates the tracking state for each sample.
// Stall: when m_tready is low the result register holds its beat; the input
//   register still takes one more sample, then s_tready drops until the
//   result is taken.
// Reset (aresetn low, synchronous): both pipeline registers empty, tracking
//   state back to unknown, configuration back to its defaults.
module corridor_breach_monitor (
    input  wire                             aclk,
    input  wire                             aresetn,
    // slave channel
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [63:0]                     s_tdata,   // margin_mm[31:0], now_ms[63:32]
    input  wire  [0:0]                      s_tuser,   // margin_valid[0]
    // master channel
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [31:0]                     m_tdata,   // margin_echo_mm[31:0]
    output logic [3:0]                      m_tuser,   // corridor_state[1:0],
                                                       // breach_entered[2], breach_cleared[3]
    // configuration writes
    input  wire                             cfg_we,
    input  wire  [cbm_pkg::CfgAddrW-1:0]    cfg_addr,
    input  wire  [cbm_pkg::CfgDataW-1:0]    cfg_wdata
);

    cbm_pkg::cfg_t     cfg;
    cbm_pkg::sample_t  in_reg;
    logic              in_valid_reg;
    cbm_pkg::result_t  res_next;
    cbm_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic              step;

    // Classify stage moves when it holds a sample and the result slot frees up.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    cbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbm_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .sample  (in_reg),
        .res     (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.margin_mm    <= $signed(s_tdata[31:0]);
            in_reg.now_ms       <= s_tdata[63:32];
            in_reg.margin_valid <= s_tuser[0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.margin_echo_mm;
    assign m_tuser  = {out_reg.breach_cleared, out_reg.breach_entered, out_reg.corridor_state};

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !step)
        else $error("result overwritten while stalled");

    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("classified beat lost");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input blocked while empty");
`endif

endmodule

`default_nettype wire
